// ===== rtl/mptw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mptw_pkg
// Shared types and constants of the multilevel page table walker: request
// and response payloads, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package mptw_pkg;

  localparam int VA_W = 39;
  localparam int PA_W = 20;

  // Defaults for the top-level parameters
  localparam int LEVEL_COUNT_DEF = 3;
  localparam int OFFSET_BITS_DEF = 12;
  localparam int FRAME_COUNT_DEF = 256;

  // log2 of the bytes per table entry; index bits = offset bits - this
  localparam int ENTRY_SHIFT = 3;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_ALLOCATE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_NO_FRAMES  = 2'd2
  } status_t;

  typedef struct packed {
    logic            op;
    logic [VA_W-1:0] virt_addr;
  } req_t;

  typedef struct packed {
    status_t         status;
    logic [PA_W-1:0] phys_addr;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/multilevel_page_table_walker_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_page_table_walker_unit
// Radix page table walker with an internal frame memory and bump allocator.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with in_req (op, virt_addr). op
//   translate walks LEVEL_COUNT table levels and returns the physical address
//   or not-mapped; op allocate walks the same path, creating missing tables
//   and the data page from the free-frame allocator.
//   One response per request leaves on out_valid/out_ready with out_rsp
//   (status, phys_addr). Requests are served one at a time, in order.
// Timing:
//   All tables live in one single-port memory with a registered read. Each
//   level costs one read; a full translate raises out_valid in the same
//   cycle as it frees the input, and no new request is taken while one is
//   being walked. Every frame an allocate creates adds a zero-fill sweep over
//   its 2^(OFFSET_BITS-3) entries; below the root it also needs a link write
//   and, above the last level, a reissued read.
// Reset:
//   rst_n clears the root, the allocator and all handshake state. Frame
//   memory is not cleared; every frame is zero-filled as it is taken.
// Stall:
//   A finished response holds in the output register while out_ready is
//   low; the walker may take and walk one more request, then waits in its
//   done state and takes no new request until the register drains.
// ----------------------------------------------------------------------------
module multilevel_page_table_walker_unit #(
  parameter int LEVEL_COUNT = mptw_pkg::LEVEL_COUNT_DEF,
  parameter int OFFSET_BITS = mptw_pkg::OFFSET_BITS_DEF,
  parameter int FRAME_COUNT = mptw_pkg::FRAME_COUNT_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire mptw_pkg::req_t  in_req,
  output logic                 out_valid,
  input  wire                  out_ready,
  output mptw_pkg::rsp_t       out_rsp
);
  import mptw_pkg::*;

  localparam int IW        = OFFSET_BITS - ENTRY_SHIFT;         // index bits per level
  localparam int FB        = $clog2(FRAME_COUNT);               // frame number bits
  localparam int NFW       = $clog2(FRAME_COUNT + 1);           // allocator count bits
  localparam int EW        = FB + 1;                            // entry: frame, valid
  localparam int AW        = FB + IW;                           // memory address bits
  localparam int MEM_DEPTH = FRAME_COUNT * (1 << IW);
  localparam int WW        = LEVEL_COUNT * IW;                  // walked index bits
  localparam int LVW       = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CHK  = 6'b000100,
    S_FILL = 6'b001000,
    S_LINK = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  // Control registers
  state_t           state_r, state_nxt;
  logic             root_present_r, root_present_nxt;
  logic [FB-1:0]    root_frame_r, root_frame_nxt;
  logic [NFW-1:0]   next_free_r, next_free_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LVW-1:0]   level_r, level_nxt;
  logic [IW-1:0]    fill_cnt_r, fill_cnt_nxt;

  // Payload registers
  logic             op_r, op_nxt;
  logic [WW-1:0]    idx_sr_r, idx_sr_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [FB-1:0]    frame_r, frame_nxt;
  logic [FB-1:0]    fill_frame_r, fill_frame_nxt;
  logic             link_pending_r, link_pending_nxt;
  logic [AW-1:0]    link_addr_r, link_addr_nxt;
  rsp_t             res_r, res_nxt;
  rsp_t             out_rsp_r, out_rsp_nxt;

  // Frame memory
  logic [EW-1:0]    mem [MEM_DEPTH];
  logic [EW-1:0]    rdata_r;
  logic [AW-1:0]    rd_addr_r;
  logic [AW-1:0]    mem_addr;
  logic             mem_we;
  logic [EW-1:0]    mem_wdata;

  // Walk helpers
  logic [VA_W+WW-1:0]        va_ext;
  logic [WW-1:0]             idx_shift;
  logic [IW-1:0]             idx_cur;
  logic [IW-1:0]             idx_next;
  logic [FB-1:0]             rd_frame;
  logic                      rd_usable;
  logic                      last_level;
  logic                      frames_left;
  logic [FB-1:0]             free_frame;
  logic [PA_W+FB+OFFSET_BITS-1:0] pa_wide;
  logic                      in_fire;

  assign va_ext      = {{WW{1'b0}}, in_req.virt_addr} >> OFFSET_BITS;
  assign idx_shift   = idx_sr_r << IW;
  assign idx_cur     = idx_sr_r[WW-1 -: IW];
  assign idx_next    = idx_shift[WW-1 -: IW];
  assign rd_frame    = rdata_r[EW-1:1];
  assign rd_usable   = rdata_r[0] && ({1'b0, rd_frame} < (FB+1)'(FRAME_COUNT));
  assign last_level  = (level_r == LVW'(LEVEL_COUNT - 1));
  assign frames_left = (next_free_r < NFW'(FRAME_COUNT));
  assign free_frame  = next_free_r[FB-1:0];
  assign pa_wide     = {{PA_W{1'b0}}, rd_frame, offset_r};

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Memory port: one access per cycle, read data registered
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    mem_addr  = {frame_r, idx_cur};
    unique case (state_r)
      S_CHK:  mem_addr = {rd_frame, idx_next};
      S_FILL: begin
        mem_we   = 1'b1;
        mem_addr = {fill_frame_r, fill_cnt_r};
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_addr  = link_addr_r;
        mem_wdata = {fill_frame_r, 1'b1};
      end
      S_IDLE, S_RD, S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r   <= mem[mem_addr];
    rd_addr_r <= mem_addr;
  end

  // Walk sequencer
  always_comb begin
    state_nxt        = state_r;
    root_present_nxt = root_present_r;
    root_frame_nxt   = root_frame_r;
    next_free_nxt    = next_free_r;
    level_nxt        = level_r;
    fill_cnt_nxt     = fill_cnt_r;
    op_nxt           = op_r;
    idx_sr_nxt       = idx_sr_r;
    offset_nxt       = offset_r;
    frame_nxt        = frame_r;
    fill_frame_nxt   = fill_frame_r;
    link_pending_nxt = link_pending_r;
    link_addr_nxt    = link_addr_r;
    res_nxt          = res_r;
    out_rsp_nxt      = out_rsp_r;
    out_valid_nxt    = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt        = in_req.op;
          idx_sr_nxt    = va_ext[WW-1:0];
          offset_nxt    = in_req.virt_addr[OFFSET_BITS-1:0];
          level_nxt     = '0;
          res_nxt       = '0;
          frame_nxt     = root_frame_r;
          link_pending_nxt = 1'b0;
          if (root_present_r) begin
            state_nxt = S_RD;
          end else if (in_req.op == OP_TRANSLATE) begin
            res_nxt.status = ST_NOT_MAPPED;
            state_nxt      = S_DONE;
          end else if (!frames_left) begin
            res_nxt.status = ST_NO_FRAMES;
            state_nxt      = S_DONE;
          end else begin
            // Take a root frame, clear it, then start the walk
            root_present_nxt = 1'b1;
            root_frame_nxt   = free_frame;
            frame_nxt        = free_frame;
            fill_frame_nxt   = free_frame;
            next_free_nxt    = next_free_r + 1'b1;
            state_nxt        = S_FILL;
          end
        end
      end

      S_RD: state_nxt = S_CHK;

      S_CHK: begin
        if (rd_usable) begin
          frame_nxt = rd_frame;
          if (last_level) begin
            res_nxt.status = ST_OK;
            if (op_r == OP_TRANSLATE) begin
              res_nxt.phys_addr = pa_wide[PA_W-1:0];
            end
            state_nxt = S_DONE;
          end else begin
            // Next read already issued this cycle; advance the level
            level_nxt  = level_r + 1'b1;
            idx_sr_nxt = idx_shift;
          end
        end else if (op_r == OP_TRANSLATE) begin
          res_nxt.status = ST_NOT_MAPPED;
          state_nxt      = S_DONE;
        end else if (!frames_left) begin
          res_nxt.status = ST_NO_FRAMES;
          state_nxt      = S_DONE;
        end else begin
          fill_frame_nxt   = free_frame;
          next_free_nxt    = next_free_r + 1'b1;
          link_pending_nxt = 1'b1;
          link_addr_nxt    = rd_addr_r;
          state_nxt        = S_FILL;
        end
      end

      S_FILL: begin
        fill_cnt_nxt = fill_cnt_r + 1'b1;
        if (&fill_cnt_r) begin
          state_nxt = link_pending_r ? S_LINK : S_RD;
        end
      end

      S_LINK: begin
        frame_nxt        = fill_frame_r;
        link_pending_nxt = 1'b0;
        if (last_level) begin
          res_nxt.status = ST_OK;
          state_nxt      = S_DONE;
        end else begin
          level_nxt  = level_r + 1'b1;
          idx_sr_nxt = idx_shift;
          state_nxt  = S_RD;
        end
      end

      S_DONE: begin
        // Hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_rsp_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      root_present_r <= 1'b0;
      root_frame_r   <= '0;
      next_free_r    <= '0;
      out_valid_r    <= 1'b0;
      level_r        <= '0;
      fill_cnt_r     <= '0;
    end else begin
      state_r        <= state_nxt;
      root_present_r <= root_present_nxt;
      root_frame_r   <= root_frame_nxt;
      next_free_r    <= next_free_nxt;
      out_valid_r    <= out_valid_nxt;
      level_r        <= level_nxt;
      fill_cnt_r     <= fill_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    idx_sr_r       <= idx_sr_nxt;
    offset_r       <= offset_nxt;
    frame_r        <= frame_nxt;
    fill_frame_r   <= fill_frame_nxt;
    link_pending_r <= link_pending_nxt;
    link_addr_r    <= link_addr_nxt;
    res_r          <= res_nxt;
    out_rsp_r      <= out_rsp_nxt;
  end

`ifndef NO_ASSERTIONS
  // The allocator never hands out more frames than exist
  a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= NFW'(FRAME_COUNT))
    else $error("allocator count beyond frame count");

  // A new link never points into the frame that holds the parent entry
  a_link_parent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINK) |-> (link_addr_r[AW-1 -: FB] != fill_frame_r))
    else $error("link written into the frame it points to");

  // An accepted request always leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("request accepted without starting a walk");

  // Once created, the root stays in place
  a_root_keep: assert property (@(posedge clk) disable iff (!rst_n)
    root_present_r |=> root_present_r)
    else $error("root lost");
`endif

endmodule
`default_nettype wire
